>>> rtl/vaxrot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaxrot_pkg
// Shared types, constants and the arctangent table for the axis rotation
// pipeline.
// ----------------------------------------------------------------------------
package vaxrot_pkg;

  // Default number of CORDIC iterations (one pipeline stage each).
  localparam int unsigned TrigIterDefault = 24;

  // Signed axis codes as they arrive on the input word.
  localparam logic [2:0] AxisCodeX = 3'd1;
  localparam logic [2:0] AxisCodeY = 3'd2;
  localparam logic [2:0] AxisCodeZ = 3'd3;

  // 360 degrees in Q16.16 is 45 * 2^19, so the reduction works on the
  // bits above bit 18 modulo 45 and keeps the low 19 bits as they are.
  localparam logic [13:0] ModBias  = 14'd4140;   // 92 * 45, makes the quotient positive
  localparam logic [10:0] ModRecip = 11'd1456;   // floor(2^16 / 45)
  localparam logic [5:0]  ModDiv   = 6'd45;

  localparam logic [24:0] Deg90  = 25'd5898240;
  localparam logic [24:0] Deg180 = 25'd11796480;
  localparam logic [24:0] Deg270 = 25'd17694720;
  localparam logic [25:0] Deg360 = 26'd23592960;

  // pi / 180 scaled by 2^46, split for two narrow partial products.
  localparam logic [40:0] DegToRad   = 41'd1228166276394;
  localparam logic [20:0] DegToRadLo = DegToRad[20:0];
  localparam logic [19:0] DegToRadHi = DegToRad[40:21];

  // CORDIC gain compensation, 0.60725 in Q2.30.
  localparam logic signed [31:0] CordicGain = 32'sh26DD3B6A;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Data that rides along the pipeline next to the angle path.
  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    axis_e              axis;
    logic               bad;
    logic               flip;
  } side_t;

  // Truncated arctangent of 2^-idx in Q2.30 radians.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'h3243F6A8;
      5'd1:  val = 32'h1DAC6705;
      5'd2:  val = 32'h0FADBAFC;
      5'd3:  val = 32'h07F56EA6;
      5'd4:  val = 32'h03FEAB76;
      5'd5:  val = 32'h01FFD55B;
      5'd6:  val = 32'h00FFFAAA;
      5'd7:  val = 32'h007FFF55;
      5'd8:  val = 32'h003FFFEA;
      5'd9:  val = 32'h001FFFFD;
      5'd10: val = 32'h000FFFFF;
      5'd11: val = 32'h0007FFFF;
      5'd12: val = 32'h0003FFFF;
      5'd13: val = 32'h0001FFFF;
      5'd14: val = 32'h0000FFFF;
      5'd15: val = 32'h00007FFF;
      5'd16: val = 32'h00003FFF;
      5'd17: val = 32'h00001FFF;
      5'd18: val = 32'h00000FFF;
      5'd19: val = 32'h000007FF;
      5'd20: val = 32'h000003FF;
      5'd21: val = 32'h000001FF;
      5'd22: val = 32'h000000FF;
      5'd23: val = 32'h0000007F;
      5'd24: val = 32'h0000003F;
      5'd25: val = 32'h0000001F;
      5'd26: val = 32'h0000000F;
      5'd27: val = 32'h00000008;
      5'd28: val = 32'h00000004;
      5'd29: val = 32'h00000002;
      5'd30: val = 32'h00000001;
      5'd31: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/vaxrot_angle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaxrot_angle
// Four-stage front end: decodes the axis, reduces the angle modulo 360
// degrees, folds it into [-90, 90] and converts it to Q2.30 radians.
// ----------------------------------------------------------------------------
module vaxrot_angle (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  input  logic signed [2:0]   axis_code_i,
  input  logic signed [31:0]  angle_deg_i,
  output logic                valid_o,
  output logic signed [31:0]  rad_o,
  output vaxrot_pkg::side_t   side_o
);

  // Stage 1: axis decode, direction, quotient estimate for mod 45.
  logic                     code_neg;
  logic [2:0]               code_abs;
  logic signed [32:0]       ang_ext;
  logic signed [32:0]       ang_dir;
  logic [14:0]              u_wide;
  logic [13:0]              u_d;
  logic [24:0]              t_prod;
  logic [7:0]               t_d;
  vaxrot_pkg::side_t        side1_d;

  assign code_neg = axis_code_i[2];
  assign code_abs = code_neg ? (~axis_code_i + 3'd1) : axis_code_i;
  assign ang_ext  = {angle_deg_i[31], angle_deg_i};
  assign ang_dir  = code_neg ? -ang_ext : ang_ext;
  assign u_wide   = {ang_dir[32], ang_dir[32:19]} + {1'b0, vaxrot_pkg::ModBias};
  assign u_d      = u_wide[13:0];
  assign t_prod   = {11'd0, u_d} * {14'd0, vaxrot_pkg::ModRecip};
  assign t_d      = t_prod[23:16];

  always_comb begin
    side1_d.vec_x = vec_x_i;
    side1_d.vec_y = vec_y_i;
    side1_d.vec_z = vec_z_i;
    side1_d.flip  = 1'b0;
    unique case (code_abs)
      vaxrot_pkg::AxisCodeX: begin
        side1_d.axis = vaxrot_pkg::AXIS_X;
        side1_d.bad  = 1'b0;
      end
      vaxrot_pkg::AxisCodeY: begin
        side1_d.axis = vaxrot_pkg::AXIS_Y;
        side1_d.bad  = 1'b0;
      end
      vaxrot_pkg::AxisCodeZ: begin
        side1_d.axis = vaxrot_pkg::AXIS_Z;
        side1_d.bad  = 1'b0;
      end
      default: begin
        side1_d.axis = vaxrot_pkg::AXIS_Z;
        side1_d.bad  = 1'b1;
      end
    endcase
  end

  logic                s1_valid_q;
  logic [13:0]         s1_u_q;
  logic [7:0]          s1_t_q;
  logic [18:0]         s1_low_q;
  vaxrot_pkg::side_t   s1_side_q;

  // Stage 2: finish the remainder and fold the angle.
  logic [13:0]         r_pre;
  logic [6:0]          r_wide;
  logic [5:0]          r_d;
  logic [24:0]         deg_m;
  logic signed [25:0]  deg_f;
  logic                flip_d;
  logic [25:0]         mag_full;
  vaxrot_pkg::side_t   side2_d;

  assign r_pre  = s1_u_q - ({6'd0, s1_t_q} * {8'd0, vaxrot_pkg::ModDiv});
  assign r_wide = r_pre[6:0];
  assign r_d    = (r_wide >= {1'b0, vaxrot_pkg::ModDiv}) ?
                  6'(r_wide - {1'b0, vaxrot_pkg::ModDiv}) : r_wide[5:0];
  assign deg_m  = {r_d, s1_low_q};

  always_comb begin
    if (deg_m <= vaxrot_pkg::Deg90) begin
      deg_f  = signed'({1'b0, deg_m});
      flip_d = 1'b0;
    end else if (deg_m < vaxrot_pkg::Deg270) begin
      deg_f  = signed'({1'b0, deg_m} - {1'b0, vaxrot_pkg::Deg180});
      flip_d = 1'b1;
    end else begin
      deg_f  = signed'({1'b0, deg_m} - vaxrot_pkg::Deg360);
      flip_d = 1'b0;
    end
  end

  assign mag_full = deg_f[25] ? 26'(-deg_f) : 26'(deg_f);

  always_comb begin
    side2_d      = s1_side_q;
    side2_d.flip = flip_d;
  end

  logic                s2_valid_q;
  logic [22:0]         s2_mag_q;
  logic                s2_rneg_q;
  vaxrot_pkg::side_t   s2_side_q;

  // Stage 3: partial products of the degree-to-radian scale.
  logic [43:0]         pp_lo_d;
  logic [42:0]         pp_hi_d;

  assign pp_lo_d = {21'd0, s2_mag_q} * {23'd0, vaxrot_pkg::DegToRadLo};
  assign pp_hi_d = {20'd0, s2_mag_q} * {23'd0, vaxrot_pkg::DegToRadHi};

  logic                s3_valid_q;
  logic [43:0]         s3_pp_lo_q;
  logic [42:0]         s3_pp_hi_q;
  logic                s3_rneg_q;
  vaxrot_pkg::side_t   s3_side_q;

  // Stage 4: combine, round half up, restore the sign.
  logic [63:0]         rad_sum;
  logic signed [31:0]  rad_mag;
  logic signed [31:0]  rad_d;

  assign rad_sum = {s3_pp_hi_q[42:0], 21'd0} + {20'd0, s3_pp_lo_q} + 64'h0000_0000_8000_0000;
  assign rad_mag = signed'(rad_sum[63:32]);
  assign rad_d   = s3_rneg_q ? -rad_mag : rad_mag;

  logic                s4_valid_q;
  logic signed [31:0]  s4_rad_q;
  vaxrot_pkg::side_t   s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_u_q     <= u_d;
      s1_t_q     <= t_d;
      s1_low_q   <= ang_dir[18:0];
      s1_side_q  <= side1_d;
      s2_mag_q   <= mag_full[22:0];
      s2_rneg_q  <= deg_f[25];
      s2_side_q  <= side2_d;
      s3_pp_lo_q <= pp_lo_d;
      s3_pp_hi_q <= pp_hi_d;
      s3_rneg_q  <= s2_rneg_q;
      s3_side_q  <= s2_side_q;
      s4_rad_q   <= rad_d;
      s4_side_q  <= s3_side_q;
    end
  end

  assign valid_o = s4_valid_q;
  assign rad_o   = s4_rad_q;
  assign side_o  = s4_side_q;

endmodule

>>> rtl/vaxrot_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vaxrot_cordic
// Rotation-mode CORDIC, one registered stage per iteration, giving cosine
// and sine in Q2.30.
// ----------------------------------------------------------------------------
module vaxrot_cordic #(
  parameter int unsigned Iterations = vaxrot_pkg::TrigIterDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [31:0]  rad_i,
  input  vaxrot_pkg::side_t   side_i,
  output logic                valid_o,
  output logic signed [31:0]  cos_o,
  output logic signed [31:0]  sin_o,
  output vaxrot_pkg::side_t   side_o
);

  logic signed [31:0] x_c    [Iterations+1];
  logic signed [31:0] y_c    [Iterations+1];
  logic signed [31:0] z_c    [Iterations];
  vaxrot_pkg::side_t  side_c [Iterations+1];
  logic               valid_c[Iterations+1];

  assign x_c[0]     = vaxrot_pkg::CordicGain;
  assign y_c[0]     = '0;
  assign z_c[0]     = rad_i;
  assign side_c[0]  = side_i;
  assign valid_c[0] = valid_i;

  for (genvar i = 0; i < Iterations; i++) begin : g_iter
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] x_d;
    logic signed [31:0] y_d;
    logic               valid_q;
    logic signed [31:0] x_q;
    logic signed [31:0] y_q;
    vaxrot_pkg::side_t  side_q;

    assign dx = y_c[i] >>> i;
    assign dy = x_c[i] >>> i;

    // A residual of exactly zero turns the positive way.
    always_comb begin
      if (!z_c[i][31]) begin
        x_d = x_c[i] - dx;
        y_d = y_c[i] + dy;
      end else begin
        x_d = x_c[i] + dx;
        y_d = y_c[i] - dy;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_c[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q    <= x_d;
        y_q    <= y_d;
        side_q <= side_c[i];
      end
    end

    // The residual only steers the next iteration, so the last stage has none.
    if (i + 1 < Iterations) begin : g_res
      localparam logic signed [31:0] Atan = signed'(vaxrot_pkg::atan_q30(5'(i)));

      logic signed [31:0] z_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q <= z_c[i][31] ? (z_c[i] + Atan) : (z_c[i] - Atan);
        end
      end

      assign z_c[i+1] = z_q;
    end

    assign x_c[i+1]     = x_q;
    assign y_c[i+1]     = y_q;
    assign side_c[i+1]  = side_q;
    assign valid_c[i+1] = valid_q;
  end

  assign valid_o = valid_c[Iterations];
  assign cos_o   = x_c[Iterations];
  assign sin_o   = y_c[Iterations];
  assign side_o  = side_c[Iterations];

endmodule

>>> rtl/vector_axis_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_axis_rotation
// Rotates a Q8.24 3-vector clockwise about the x, y or z axis by an angle
// given in Q16.16 degrees, with saturated Q8.24 results.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one word per cycle: the vector, a signed axis
//   code (1, 2, 3 for x, y, z; the negated code turns the other way) and the
//   angle. A word is taken at a rising edge where in_valid_i is high and
//   in_stall_o is low. The output channel gives one word per input word, in
//   order, taken where out_valid_o is high and out_stall_i is low. An axis
//   code of 0 or -4 returns the vector unchanged with bad_axis_o set.
//   The pipeline has four angle stages, one stage per CORDIC iteration,
//   then operand select, multiply, sum and round/saturate, the last being
//   the output register. Throughput is one word per cycle; the CORDIC
//   iteration chain sets the depth and the four 32x32 multipliers in the
//   multiply stage set the width. When the receiver stalls a valid output
//   word, the whole pipeline holds and in_stall_o rises in the same cycle;
//   nothing is dropped or repeated. Reset clears every valid bit, so the
//   block comes up empty.
// ----------------------------------------------------------------------------
module vector_axis_rotation #(
  parameter int unsigned TRIG_ITERATIONS = vaxrot_pkg::TrigIterDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  input  logic signed [2:0]   axis_code_i,
  input  logic signed [31:0]  angle_deg_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  res_x_o,
  output logic signed [31:0]  res_y_o,
  output logic signed [31:0]  res_z_o,
  output logic                bad_axis_o
);

  // Round Q11.54 to Q8.24 (half up) and clamp to the 32-bit range.
  function automatic logic signed [31:0] sat_q24(input logic signed [64:0] acc);
    logic signed [64:0] biased;
    logic signed [34:0] shifted;
    logic signed [31:0] val;
    biased  = acc + 65'sd536870912;
    shifted = biased[64:30];
    if (shifted[34:31] == {4{shifted[31]}}) begin
      val = shifted[31:0];
    end else if (shifted[34]) begin
      val = 32'sh8000_0000;
    end else begin
      val = 32'sh7FFF_FFFF;
    end
    return val;
  endfunction

  // The pipeline moves as a whole unless the output word is held.
  logic out_valid_q;
  logic en;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Angle front end and CORDIC.
  logic                ang_valid;
  logic signed [31:0]  ang_rad;
  vaxrot_pkg::side_t   ang_side;

  vaxrot_angle u_angle (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .axis_code_i (axis_code_i),
    .angle_deg_i (angle_deg_i),
    .valid_o     (ang_valid),
    .rad_o       (ang_rad),
    .side_o      (ang_side)
  );

  logic                cor_valid;
  logic signed [31:0]  cor_cos;
  logic signed [31:0]  cor_sin;
  vaxrot_pkg::side_t   cor_side;

  vaxrot_cordic #(
    .Iterations (TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ang_valid),
    .rad_i   (ang_rad),
    .side_i  (ang_side),
    .valid_o (cor_valid),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin),
    .side_o  (cor_side)
  );

  // Operand select. Each axis reduces to a' = a*c + b*s, b' = b*c - a*s;
  // rotation about y uses the opposite sign of the sine. A folded angle
  // negates both sine and cosine.
  logic signed [31:0]  c_fold;
  logic signed [31:0]  s_fold;
  logic signed [31:0]  s_d;
  logic signed [31:0]  a_d;
  logic signed [31:0]  b_d;

  assign c_fold = cor_side.flip ? -cor_cos : cor_cos;
  assign s_fold = cor_side.flip ? -cor_sin : cor_sin;
  assign s_d    = (cor_side.axis == vaxrot_pkg::AXIS_Y) ? -s_fold : s_fold;

  always_comb begin
    unique case (cor_side.axis)
      vaxrot_pkg::AXIS_X: begin
        a_d = cor_side.vec_y;
        b_d = cor_side.vec_z;
      end
      vaxrot_pkg::AXIS_Y: begin
        a_d = cor_side.vec_x;
        b_d = cor_side.vec_z;
      end
      default: begin
        a_d = cor_side.vec_x;
        b_d = cor_side.vec_y;
      end
    endcase
  end

  logic                p_valid_q;
  logic signed [31:0]  p_c_q;
  logic signed [31:0]  p_s_q;
  logic signed [31:0]  p_a_q;
  logic signed [31:0]  p_b_q;
  vaxrot_pkg::side_t   p_side_q;

  // Multiply stage.
  logic signed [63:0]  ac_d;
  logic signed [63:0]  bs_d;
  logic signed [63:0]  as_d;
  logic signed [63:0]  bc_d;

  assign ac_d = p_a_q * p_c_q;
  assign bs_d = p_b_q * p_s_q;
  assign as_d = p_a_q * p_s_q;
  assign bc_d = p_b_q * p_c_q;

  logic                m_valid_q;
  logic signed [63:0]  m_ac_q;
  logic signed [63:0]  m_bs_q;
  logic signed [63:0]  m_as_q;
  logic signed [63:0]  m_bc_q;
  vaxrot_pkg::side_t   m_side_q;

  // Sum stage.
  logic signed [64:0]  sa_d;
  logic signed [64:0]  sb_d;

  assign sa_d = 65'(m_ac_q) + 65'(m_bs_q);
  assign sb_d = 65'(m_bc_q) - 65'(m_as_q);

  logic                s_valid_q;
  logic signed [64:0]  s_sa_q;
  logic signed [64:0]  s_sb_q;
  vaxrot_pkg::side_t   s_side_q;

  // Round, saturate and put the two results back in place; the component
  // on the rotation axis, and the whole vector for a bad code, pass through.
  logic signed [31:0]  ra;
  logic signed [31:0]  rb;
  logic signed [31:0]  res_x_d;
  logic signed [31:0]  res_y_d;
  logic signed [31:0]  res_z_d;

  assign ra = sat_q24(s_sa_q);
  assign rb = sat_q24(s_sb_q);

  always_comb begin
    res_x_d = s_side_q.vec_x;
    res_y_d = s_side_q.vec_y;
    res_z_d = s_side_q.vec_z;
    if (!s_side_q.bad) begin
      unique case (s_side_q.axis)
        vaxrot_pkg::AXIS_X: begin
          res_y_d = ra;
          res_z_d = rb;
        end
        vaxrot_pkg::AXIS_Y: begin
          res_x_d = ra;
          res_z_d = rb;
        end
        default: begin
          res_x_d = ra;
          res_y_d = rb;
        end
      endcase
    end
  end

  logic signed [31:0]  res_x_q;
  logic signed [31:0]  res_y_q;
  logic signed [31:0]  res_z_q;
  logic                bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q   <= cor_valid;
      m_valid_q   <= p_valid_q;
      s_valid_q   <= m_valid_q;
      out_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_c_q    <= c_fold;
      p_s_q    <= s_d;
      p_a_q    <= a_d;
      p_b_q    <= b_d;
      p_side_q <= cor_side;
      m_ac_q   <= ac_d;
      m_bs_q   <= bs_d;
      m_as_q   <= as_d;
      m_bc_q   <= bc_d;
      m_side_q <= p_side_q;
      s_sa_q   <= sa_d;
      s_sb_q   <= sb_d;
      s_side_q <= m_side_q;
      res_x_q  <= res_x_d;
      res_y_q  <= res_y_d;
      res_z_q  <= res_z_d;
      bad_q    <= s_side_q.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_x_o     = res_x_q;
  assign res_y_o     = res_y_q;
  assign res_z_o     = res_z_q;
  assign bad_axis_o  = bad_q;

  // A held output freezes the inner stages as well.
  a_hold_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(p_valid_q) && $stable(m_valid_q) && $stable(s_valid_q))
    else $error("inner pipeline moved while the output word was held");

  // An output word only appears when the sum stage held one.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s_valid_q))
    else $error("output word appeared from an empty pipeline");

  // A bad axis code returns the vector it came with.
  a_bad_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s_valid_q && s_side_q.bad) |=>
      (bad_axis_o && res_x_o == $past(s_side_q.vec_x)
       && res_y_o == $past(s_side_q.vec_y) && res_z_o == $past(s_side_q.vec_z)))
    else $error("bad axis word did not pass the vector through");

  // Rotation about z leaves the z component alone.
  a_keep_z: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s_valid_q && !s_side_q.bad && s_side_q.axis == vaxrot_pkg::AXIS_Z) |=>
      (!bad_axis_o && res_z_o == $past(s_side_q.vec_z)))
    else $error("z component changed under a rotation about z");

endmodule
